[rtl/core/tks_pkg.sv]
// Package for the top-k score selector.
// Holds field widths, the reset value of the report count and the
// command and status structs between controller and datapath. No dependencies.
package tks_pkg;

   // Field widths fixed by the interface
   localparam int SCORE_W = 32;
   localparam int IDX_W   = 10;
   localparam int TC_W    = 4;

   // Report count after reset
   localparam logic [TC_W-1:0] TOP_COUNT_RESET = 4'd5;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic insert;    // rank the accepted score word
      logic pop;       // move the head entry into the result register
      logic pop_last;  // the popped entry is the final result of the vector
      logic clear;     // empty the list and restart the position count
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;  // result register can take a new word this cycle
   } status_type;

endpackage

[rtl/core/tks_datapath.sv]
// Datapath of the top-k score selector: sorted insertion chain of kept
// scores and class positions, position counter, fill count, result register.
// Depends on tks_pkg.
module tks_datapath #(
   parameter int MAX_TOP     = 8,
   parameter int MAX_CLASSES = 1024,
   localparam int FW = $clog2(MAX_TOP + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tks_pkg::cmd_type                    cmd,
   output tks_pkg::status_type                 status,
   output logic [FW-1:0]                       fill,
   input  logic signed [tks_pkg::SCORE_W-1:0]  req_score,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tks_pkg::IDX_W-1:0]           rsp_class_index,
   output logic signed [tks_pkg::SCORE_W-1:0]  rsp_best_score,
   output logic                                rsp_last_result
);

   localparam int PW = $clog2(MAX_CLASSES + 1);

   // Kept list, sorted by descending score; valid entries form a prefix
   logic signed [tks_pkg::SCORE_W-1:0] score_ff [MAX_TOP];
   logic signed [tks_pkg::SCORE_W-1:0] score_in [MAX_TOP];
   logic [tks_pkg::IDX_W-1:0]          idx_ff   [MAX_TOP];
   logic [tks_pkg::IDX_W-1:0]          idx_in   [MAX_TOP];
   logic [MAX_TOP-1:0]                 valid_ff, valid_in;
   logic [FW-1:0]                      fill_ff, fill_in;
   logic [PW-1:0]                      pos_ff, pos_in;

   // Result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [tks_pkg::IDX_W-1:0]          rsp_idx_ff, rsp_idx_in;
   logic signed [tks_pkg::SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic                               rsp_last_ff, rsp_last_in;

   // Neighbor views of the chain
   logic signed [tks_pkg::SCORE_W-1:0] up_score [MAX_TOP];
   logic [tks_pkg::IDX_W-1:0]          up_idx   [MAX_TOP];
   logic [MAX_TOP-1:0]                 up_valid;
   logic signed [tks_pkg::SCORE_W-1:0] dn_score [MAX_TOP];
   logic [tks_pkg::IDX_W-1:0]          dn_idx   [MAX_TOP];
   logic [MAX_TOP-1:0]                 dn_valid;

   logic [MAX_TOP-1:0]                 ge, ge_prev;
   logic                               rank;
   logic [tks_pkg::IDX_W-1:0]          new_idx;

   assign rank    = pos_ff < PW'(MAX_CLASSES);
   assign new_idx = tks_pkg::IDX_W'(pos_ff);

   // Compare every kept entry against the incoming score
   always_comb begin
      for (int j = 0; j < MAX_TOP; j++) begin
         ge[j] = valid_ff[j] && (score_ff[j] >= req_score);
      end
      ge_prev[0] = 1'b1;
      for (int j = 1; j < MAX_TOP; j++) begin
         ge_prev[j] = ge[j-1];
      end
   end

   // Build shifted copies for insertion (from above) and popping (from below)
   always_comb begin
      up_score[0] = req_score;
      up_idx[0]   = new_idx;
      up_valid[0] = 1'b1;
      for (int j = 1; j < MAX_TOP; j++) begin
         up_score[j] = score_ff[j-1];
         up_idx[j]   = idx_ff[j-1];
         up_valid[j] = valid_ff[j-1];
      end
      for (int j = 0; j < MAX_TOP - 1; j++) begin
         dn_score[j] = score_ff[j+1];
         dn_idx[j]   = idx_ff[j+1];
         dn_valid[j] = valid_ff[j+1];
      end
      dn_score[MAX_TOP-1] = score_ff[MAX_TOP-1];
      dn_idx[MAX_TOP-1]   = idx_ff[MAX_TOP-1];
      dn_valid[MAX_TOP-1] = 1'b0;
   end

   // Next state of the list: clear, pop toward the head, or insert in place
   always_comb begin
      score_in = score_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      priority if (cmd.clear) begin
         valid_in = '0;
         fill_in  = '0;
         pos_in   = '0;
      end else if (cmd.pop) begin
         score_in = dn_score;
         idx_in   = dn_idx;
         valid_in = dn_valid;
      end else if (cmd.insert && rank) begin
         for (int j = 0; j < MAX_TOP; j++) begin
            if (!ge[j]) begin
               if (ge_prev[j]) begin
                  score_in[j] = req_score;
                  idx_in[j]   = new_idx;
                  valid_in[j] = 1'b1;
               end else begin
                  score_in[j] = up_score[j];
                  idx_in[j]   = up_idx[j];
                  valid_in[j] = up_valid[j];
               end
            end
         end
         pos_in = pos_ff + PW'(1);
         if (fill_ff != FW'(MAX_TOP)) begin
            fill_in = fill_ff + FW'(1);
         end
      end
   end

   // Load the result register on pop, drop the word once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_score_in = rsp_score_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.pop) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = idx_ff[0];
         rsp_score_in = score_ff[0];
         rsp_last_in  = cmd.pop_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      score_ff     <= score_in;
      idx_ff       <= idx_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_score_ff <= rsp_score_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign fill            = fill_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = rsp_idx_ff;
   assign rsp_best_score  = rsp_score_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

[rtl/core/tks_ctrl.sv]
// Controller of the top-k score selector: report count register and the
// collect / count / emit state machine that sequences the datapath.
// Depends on tks_pkg.
module tks_ctrl #(
   parameter int MAX_TOP = 8,
   localparam int FW = $clog2(MAX_TOP + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [tks_pkg::TC_W-1:0]   csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_is_last,
   input  tks_pkg::status_type        status,
   input  logic [FW-1:0]              fill,
   output tks_pkg::cmd_type           cmd
);

   localparam int CW = (FW > tks_pkg::TC_W) ? FW : tks_pkg::TC_W;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_COUNT,
      ST_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [tks_pkg::TC_W-1:0]   top_count_ff, top_count_in;
   logic [FW-1:0]              remain_ff, remain_in;

   logic [CW-1:0]              tc_floor, limit, fill_ext, count;
   logic                       accept, pop, pop_last;

   // Clamp the report count to 1..MAX_TOP and cap it by the fill
   always_comb begin
      tc_floor = (top_count_ff == '0) ? CW'(1) : CW'(top_count_ff);
      limit    = (tc_floor > CW'(MAX_TOP)) ? CW'(MAX_TOP) : tc_floor;
      fill_ext = CW'(fill);
      count    = (fill_ext < limit) ? fill_ext : limit;
   end

   assign req_ready = (state_ff == ST_COLLECT);
   assign accept    = req_valid && req_ready;
   assign pop       = (state_ff == ST_EMIT) && status.out_free;
   assign pop_last  = (remain_ff == FW'(1));

   // Commands to the datapath
   always_comb begin
      cmd.insert   = accept;
      cmd.pop      = pop;
      cmd.pop_last = pop_last;
      cmd.clear    = (pop && pop_last) || ((state_ff == ST_COUNT) && (count == '0));
   end

   // Next state
   always_comb begin
      state_in     = state_ff;
      remain_in    = remain_ff;
      top_count_in = top_count_ff;
      if (csr_write_enable) begin
         top_count_in = csr_write_data;
      end
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept && req_is_last) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            remain_in = FW'(count);
            state_in  = (count == '0) ? ST_COLLECT : ST_EMIT;
         end
         ST_EMIT: begin
            if (pop) begin
               remain_in = remain_ff - FW'(1);
               if (pop_last) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // Hold state, remaining count and report count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         remain_ff    <= '0;
         top_count_ff <= tks_pkg::TOP_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         top_count_ff <= top_count_in;
      end
   end

endmodule

[rtl/core/top_k_score_selector.sv]
// Top level of the top-k score selector.
// Instantiates tks_ctrl and tks_datapath; depends on tks_pkg.
//
// Usage:
//   Score words stream in on the req_ channel (req_score, signed Q16.16,
//   and req_is_last on the final score of a vector), valid/ready handshake.
//   The class position of a score is its order within the vector.
//   While a vector is collected the block takes one score word per cycle;
//   each word is ranked in a sorted chain of MAX_TOP entries in that cycle.
//   After the word with req_is_last is taken, req_ready drops; in the
//   count state that follows, the result count min(top_count, scores kept)
//   is set, and results leave on the rsp_ channel one per cycle while the
//   receiver does not stall, best first, ties by lower class position,
//   rsp_last_result on the final one. Once the final result is in the
//   output register, req_ready rises again.
//   A stalled receiver holds the result word in its output register and
//   the chain waits; nothing is lost. Scores past MAX_CLASSES positions are
//   not ranked, but their req_is_last still ends the vector.
//   csr_write_enable writes top_count (0 acts as 1, values above MAX_TOP
//   act as MAX_TOP); write it only while the block is idle.
//   Synchronous reset empties the list, clears the position count, drops
//   rsp_valid and sets top_count to 5.
module top_k_score_selector #(
   parameter int MAX_TOP     = 8,
   parameter int MAX_CLASSES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [tks_pkg::TC_W-1:0]            csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tks_pkg::SCORE_W-1:0]  req_score,
   input  logic                                req_is_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tks_pkg::IDX_W-1:0]           rsp_class_index,
   output logic signed [tks_pkg::SCORE_W-1:0]  rsp_best_score,
   output logic                                rsp_last_result
);

   localparam int FW = $clog2(MAX_TOP + 1);

   tks_pkg::cmd_type    cmd;
   tks_pkg::status_type status;
   logic [FW-1:0]       fill;

   // Sequence the vector
   tks_ctrl #(
      .MAX_TOP (MAX_TOP)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_is_last      (req_is_last),
      .status           (status),
      .fill             (fill),
      .cmd              (cmd)
   );

   // Rank and hold the scores
   tks_datapath #(
      .MAX_TOP     (MAX_TOP),
      .MAX_CLASSES (MAX_CLASSES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .fill            (fill),
      .req_score       (req_score),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_class_index (rsp_class_index),
      .rsp_best_score  (rsp_best_score),
      .rsp_last_result (rsp_last_result)
   );

endmodule
